@@ design/assert_macros.svh @@
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/fdcd_pkg.sv @@
// Package with the types, codes and reset values of the checksum deframer.
`timescale 1ns / 1ps
`default_nettype none
package fdcd_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [1:0]  kind_t;
  typedef logic [15:0] count_t;
  typedef logic        cfg_index_t;

  localparam kind_t KIND_PAYLOAD  = 2'd0;
  localparam kind_t KIND_GOOD     = 2'd1;
  localparam kind_t KIND_BAD_SUM  = 2'd2;
  localparam kind_t KIND_TOO_LONG = 2'd3;

  localparam cfg_index_t CFG_FLAG_VALUE = 1'b0;
  localparam cfg_index_t CFG_MAX_LENGTH = 1'b1;

  localparam byte_t  FLAG_RESET    = 8'hC0;
  localparam count_t MAX_LEN_RESET = 16'd1024;

endpackage
`default_nettype wire

@@ design/flag_delimited_checksum_deframer.sv @@
// A result item is registered and appears on the output in the cycle after the byte that causes it.
// Throughput: one byte per cycle; a result register separates the output side.
// A byte is refused only while a result item waits and out_ready is low.
// Synchronous reset sets flag 0xC0, max length 1024, hunting, and an empty output.
// Frame state is a handful of flip-flops updated by one compare, add and count per byte.
`timescale 1ns / 1ps
`default_nettype none
module flag_delimited_checksum_deframer (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_write_en,
  input  fdcd_pkg::cfg_index_t cfg_index,
  input  wire [15:0]           cfg_data,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  fdcd_pkg::byte_t      data_byte,
  output logic                 out_valid,
  input  wire                  out_ready,
  output fdcd_pkg::byte_t      out_byte,
  output fdcd_pkg::kind_t      kind,
  output logic                 frame_end
);
  import fdcd_pkg::*;

  byte_t  flag_value;
  count_t max_length;

  logic   in_frame, in_frame_next;
  logic   flag_seen, flag_seen_next;
  byte_t  held_byte, held_byte_next;
  logic   held_valid, held_valid_next;
  byte_t  running_sum, running_sum_next;
  count_t byte_count, byte_count_next;

  logic   res_valid;
  byte_t  res_byte;
  kind_t  res_kind;
  logic   accept;
  logic   is_flag;
  count_t limit;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_flag  = (data_byte == flag_value);
  assign limit    = (max_length == '0) ? count_t'(1) : max_length;

  always_comb begin
    in_frame_next    = in_frame;
    flag_seen_next   = flag_seen;
    held_byte_next   = held_byte;
    held_valid_next  = held_valid;
    running_sum_next = running_sum;
    byte_count_next  = byte_count;
    res_valid        = 1'b0;
    res_byte         = '0;
    res_kind         = KIND_PAYLOAD;
    if (!in_frame) begin
      if (is_flag) begin
        flag_seen_next = 1'b1;
      end else if (flag_seen) begin
        in_frame_next    = 1'b1;
        flag_seen_next   = 1'b0;
        held_byte_next   = data_byte;
        held_valid_next  = 1'b1;
        running_sum_next = '0;
        byte_count_next  = count_t'(1);
      end
    end else if (is_flag) begin
      in_frame_next    = 1'b0;
      flag_seen_next   = 1'b1;
      held_byte_next   = '0;
      held_valid_next  = 1'b0;
      running_sum_next = '0;
      byte_count_next  = '0;
      if (held_valid) begin
        res_valid = 1'b1;
        res_kind  = (running_sum == held_byte) ? KIND_GOOD : KIND_BAD_SUM;
      end
    end else if (!held_valid) begin
      held_byte_next  = data_byte;
      held_valid_next = 1'b1;
      byte_count_next = count_t'(1);
    end else if (byte_count >= limit) begin
      in_frame_next    = 1'b0;
      flag_seen_next   = 1'b0;
      held_byte_next   = '0;
      held_valid_next  = 1'b0;
      running_sum_next = '0;
      byte_count_next  = '0;
      res_valid        = 1'b1;
      res_kind         = KIND_TOO_LONG;
    end else begin
      running_sum_next = running_sum + held_byte;
      held_byte_next   = data_byte;
      byte_count_next  = byte_count + count_t'(1);
      res_valid        = 1'b1;
      res_byte         = held_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_value <= FLAG_RESET;
      max_length <= MAX_LEN_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_FLAG_VALUE: flag_value <= cfg_data[7:0];
        CFG_MAX_LENGTH: max_length <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      flag_seen   <= 1'b0;
      held_byte   <= '0;
      held_valid  <= 1'b0;
      running_sum <= '0;
      byte_count  <= '0;
    end else if (accept) begin
      in_frame    <= in_frame_next;
      flag_seen   <= flag_seen_next;
      held_byte   <= held_byte_next;
      held_valid  <= held_valid_next;
      running_sum <= running_sum_next;
      byte_count  <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte  <= res_byte;
      kind      <= res_kind;
      frame_end <= (res_kind != KIND_PAYLOAD);
    end
  end

endmodule
`default_nettype wire

@@ design/fdcd_checker.sv @@
// Port-level checker for the checksum deframer and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fdcd_checker (
  input wire                  clk,
  input wire                  rst,
  input wire                  in_ready,
  input wire                  out_valid,
  input wire                  out_ready,
  input fdcd_pkg::byte_t      out_byte,
  input fdcd_pkg::kind_t      kind,
  input wire                  frame_end
);
  import fdcd_pkg::*;

  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(kind) && $stable(frame_end), "stalled result item changed")
  `CHK_SAME(a_stall_blocks_input, out_valid && !out_ready, !in_ready, "byte taken while result item stalled")
  `CHK_SAME(a_payload_not_end, out_valid && kind == KIND_PAYLOAD, !frame_end, "payload item marked as frame end")
  `CHK_SAME(a_status_is_end, out_valid && kind != KIND_PAYLOAD, frame_end && out_byte == '0, "status item malformed")

endmodule

bind flag_delimited_checksum_deframer fdcd_checker u_fdcd_checker (.*);
`default_nettype wire
